[design/box_iou_defines.svh]
// ----------------------------------------------------------------------------
// box_iou_defines
// Assertion macros used by the box_iou top-level design file.
// ----------------------------------------------------------------------------
`ifndef BOX_IOU_DEFINES_SVH
`define BOX_IOU_DEFINES_SVH

`ifndef SYNTHESIS

`define BIOU_ASSERT(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("box_iou assertion failed");

`define BIOU_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("box_iou implication failed");

`else

`define BIOU_ASSERT(label, expr)

`define BIOU_ASSERT_IMPLY(label, ante, cons)

`endif

`endif

[design/biou_pkg.sv]
// ----------------------------------------------------------------------------
// biou_pkg
// Types and fixed widths of the box IoU datapath.
// ----------------------------------------------------------------------------
package biou_pkg;

   localparam int COORD_BITS = 16;
   localparam int SPAN_BITS  = COORD_BITS + 3;
   localparam int AREA_BITS  = 2 * COORD_BITS;
   localparam int INTER_BITS = 2 * COORD_BITS + 4;
   localparam int REM_BITS   = INTER_BITS;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [16:0]           iou_type;

   typedef struct packed {
      coord_type first_center_x;
      coord_type first_center_y;
      coord_type first_width;
      coord_type first_height;
      coord_type second_center_x;
      coord_type second_center_y;
      coord_type second_width;
      coord_type second_height;
   } req_type;

   typedef struct packed {
      iou_type     iou_ratio;
      logic [31:0] overlap_area;
      logic [32:0] union_area;
   } rsp_type;

   typedef struct packed {
      logic                valid;
      logic                nonzero;
      logic [REM_BITS-1:0] rem;
      logic [REM_BITS-1:0] divisor;
      logic [31:0]         overlap_area;
      logic [32:0]         union_area;
   } div_stage_type;

endpackage

[design/biou_geom.sv]
// ----------------------------------------------------------------------------
// biou_geom
// Three-stage front end: spans and areas, intersection, union and first
// quotient bit.
// ----------------------------------------------------------------------------
module biou_geom (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  biou_pkg::req_type       in_data,
   output biou_pkg::div_stage_type out_stage,
   output logic                    out_q0
);

   localparam int SB = biou_pkg::SPAN_BITS;
   localparam int CB = biou_pkg::COORD_BITS;
   localparam int AB = biou_pkg::AREA_BITS;
   localparam int IB = biou_pkg::INTER_BITS;

   function automatic logic signed [SB-1:0] span(
      input logic [CB-1:0] c1, input logic [CB-1:0] d1,
      input logic [CB-1:0] c2, input logic [CB-1:0] d2);
      logic signed [SB-1:0] l1, l2, r1, r2, lft, rgt;
      l1  = $signed({2'b00, c1, 1'b0}) - $signed({3'b000, d1});
      l2  = $signed({2'b00, c2, 1'b0}) - $signed({3'b000, d2});
      r1  = $signed({2'b00, c1, 1'b0}) + $signed({3'b000, d1});
      r2  = $signed({2'b00, c2, 1'b0}) + $signed({3'b000, d2});
      lft = (l1 > l2) ? l1 : l2;
      rgt = (r1 < r2) ? r1 : r2;
      return rgt - lft;
   endfunction

   logic                 v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic signed [SB-1:0] ow_ff, ow_in, oh_ff, oh_in;
   logic [AB-1:0]        area1_ff, area1_in, area2_ff, area2_in;
   logic [IB-1:0]        inter_ff, inter_in;
   logic [AB:0]          asum_ff, asum_in;
   biou_pkg::div_stage_type stage_ff, stage_in;
   logic                 q0_ff, q0_in;
   logic [IB-1:0]        area4;
   logic [IB-1:0]        uni;
   logic                 equal;

   assign v1_in    = in_valid;
   assign ow_in    = span(in_data.first_center_x, in_data.first_width,
                          in_data.second_center_x, in_data.second_width);
   assign oh_in    = span(in_data.first_center_y, in_data.first_height,
                          in_data.second_center_y, in_data.second_height);
   assign area1_in = AB'(in_data.first_width * in_data.first_height);
   assign area2_in = AB'(in_data.second_width * in_data.second_height);

   assign v2_in    = v1_ff;
   assign inter_in = (ow_ff[SB-1] || oh_ff[SB-1]) ? '0 :
                     IB'(ow_ff[SB-2:0] * oh_ff[SB-2:0]);
   assign asum_in  = {1'b0, area1_ff} + {1'b0, area2_ff};

   assign v3_in = v2_ff;
   assign area4 = IB'({asum_ff, 2'b00});
   assign uni   = area4 - inter_ff;
   assign equal = ({1'b0, area4} == {inter_ff, 1'b0});

   always_comb begin
      stage_in              = '0;
      stage_in.valid        = v3_in;
      stage_in.nonzero      = (inter_ff != '0);
      stage_in.rem          = equal ? '0 : inter_ff;
      stage_in.divisor      = uni;
      stage_in.overlap_area = inter_ff[33:2];
      stage_in.union_area   = uni[34:2];
      q0_in                 = equal;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      ow_ff    <= ow_in;
      oh_ff    <= oh_in;
      area1_ff <= area1_in;
      area2_ff <= area2_in;
      inter_ff <= inter_in;
      asum_ff  <= asum_in;
      stage_ff <= stage_in;
      q0_ff    <= q0_in;
   end

   always_comb begin
      out_stage       = stage_ff;
      out_stage.valid = v3_ff;
      out_q0          = q0_ff;
   end

endmodule

[design/biou_div_cell.sv]
// ----------------------------------------------------------------------------
// biou_div_cell
// One restoring division step: shift, trial subtract, append a quotient bit.
// ----------------------------------------------------------------------------
module biou_div_cell #(
   parameter int QW = 17
) (
   input  logic                    clock,
   input  logic                    reset,
   input  biou_pkg::div_stage_type in_stage,
   input  logic [QW-1:0]           in_q,
   output biou_pkg::div_stage_type out_stage,
   output logic [QW-1:0]           out_q
);

   localparam int RB = biou_pkg::REM_BITS;

   biou_pkg::div_stage_type stage_ff, stage_in;
   logic [QW-1:0]           q_ff, q_in;
   logic [RB:0]             trial;
   logic [RB:0]             diff;
   logic                    take;

   assign trial = {in_stage.rem, 1'b0};
   assign diff  = trial - {1'b0, in_stage.divisor};
   assign take  = (trial >= {1'b0, in_stage.divisor});

   always_comb begin
      stage_in     = in_stage;
      stage_in.rem = take ? diff[RB-1:0] : trial[RB-1:0];
      q_in         = {in_q[QW-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.nonzero      <= stage_in.nonzero;
      stage_ff.rem          <= stage_in.rem;
      stage_ff.divisor      <= stage_in.divisor;
      stage_ff.overlap_area <= stage_in.overlap_area;
      stage_ff.union_area   <= stage_in.union_area;
      q_ff                  <= q_in;
   end

   assign out_stage = stage_ff;
   assign out_q     = q_ff;

endmodule

[design/box_iou.sv]
// Throughput: one box pair per cycle; busy stays low.
// Three front-end stages form spans, areas, the union and the first quotient bit,
// then one division cell per fraction bit yields the rest of the ratio.
// Reset clears the valid bits of every stage; results cannot be stalled.
// ----------------------------------------------------------------------------
// box_iou
// Intersection over union of two axis-aligned boxes, fully pipelined.
// ----------------------------------------------------------------------------
`include "box_iou_defines.svh"

module box_iou #(
   parameter int RATIO_FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  biou_pkg::req_type req_data,
   output logic              rsp_strobe,
   output biou_pkg::rsp_type rsp_data
);

   localparam int QW = RATIO_FRAC_BITS + 1;

   biou_pkg::div_stage_type stage_chain [0:RATIO_FRAC_BITS];
   logic [QW-1:0]           q_chain     [0:RATIO_FRAC_BITS];
   logic                    q0;

   assign busy = 1'b0;

   biou_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_data   (req_data),
      .out_stage (stage_chain[0]),
      .out_q0    (q0)
   );

   assign q_chain[0] = {{(QW-1){1'b0}}, q0};

   for (genvar k = 0; k < RATIO_FRAC_BITS; k++) begin : g_cell
      biou_div_cell #(
         .QW (QW)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_stage  (stage_chain[k]),
         .in_q      (q_chain[k]),
         .out_stage (stage_chain[k+1]),
         .out_q     (q_chain[k+1])
      );
   end

   always_comb begin
      rsp_strobe            = stage_chain[RATIO_FRAC_BITS].valid;
      rsp_data.iou_ratio    = stage_chain[RATIO_FRAC_BITS].nonzero ?
                              biou_pkg::iou_type'(q_chain[RATIO_FRAC_BITS]) : '0;
      rsp_data.overlap_area = stage_chain[RATIO_FRAC_BITS].overlap_area;
      rsp_data.union_area   = stage_chain[RATIO_FRAC_BITS].union_area;
   end

   `BIOU_ASSERT_IMPLY(a_rem_below_divisor, stage_chain[0].valid && stage_chain[0].nonzero, stage_chain[0].rem < stage_chain[0].divisor)
   `BIOU_ASSERT_IMPLY(a_overlap_within_union, rsp_strobe, {1'b0, rsp_data.overlap_area} <= rsp_data.union_area)
   `BIOU_ASSERT_IMPLY(a_empty_union_zero, rsp_strobe && rsp_data.union_area == '0, rsp_data.iou_ratio == '0 && rsp_data.overlap_area == '0)

endmodule

[test/box_iou_checker.sv]
// ----------------------------------------------------------------------------
// box_iou_checker
// Watches the box pair and result channels of box_iou. For each accepted pair
// it computes the exact overlap, union and truncated ratio in 64-bit integer
// arithmetic and queues them. Each strobed result is compared field by field
// with the oldest queued one. Mismatches and strobes with nothing queued are
// counted, and the queue depth is reported to the testbench top.
// ----------------------------------------------------------------------------
module box_iou_checker #(
   parameter int RATIO_FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  biou_pkg::req_type req_data,
   input  logic              rsp_strobe,
   input  biou_pkg::rsp_type rsp_data,
   output int                mismatch_count,
   output int                pending_count
);

   biou_pkg::rsp_type due_results[$];

   // overlap of two intervals in doubled units, negative when disjoint
   function automatic longint axis_overlap(biou_pkg::coord_type c1, biou_pkg::coord_type d1,
                                           biou_pkg::coord_type c2, biou_pkg::coord_type d2);
      longint lo1, lo2, hi1, hi2;
      lo1 = 2 * longint'(c1) - longint'(d1);
      lo2 = 2 * longint'(c2) - longint'(d2);
      hi1 = 2 * longint'(c1) + longint'(d1);
      hi2 = 2 * longint'(c2) + longint'(d2);
      return ((hi1 < hi2) ? hi1 : hi2) - ((lo1 > lo2) ? lo1 : lo2);
   endfunction

   function automatic biou_pkg::rsp_type iou_of(biou_pkg::req_type b);
      longint            ow, oh;
      logic [63:0]       inter, uni, quot;
      biou_pkg::rsp_type r;
      ow = axis_overlap(b.first_center_x, b.first_width,
                        b.second_center_x, b.second_width);
      oh = axis_overlap(b.first_center_y, b.first_height,
                        b.second_center_y, b.second_height);
      inter = (ow >= 0 && oh >= 0) ? 64'(ow * oh) : 64'd0;
      uni = 4 * (64'(b.first_width) * 64'(b.first_height)
               + 64'(b.second_width) * 64'(b.second_height)) - inter;
      quot = (inter == 0 || uni == 0) ? 64'd0 : (inter << RATIO_FRAC_BITS) / uni;
      r.iou_ratio    = quot[16:0];
      r.overlap_area = inter[33:2];
      r.union_area   = uni[34:2];
      return r;
   endfunction

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
   end

   always @(posedge clock) begin
      biou_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (due_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("box_iou: unexpected result ratio=%0d overlap=%0d union=%0d",
                           rsp_data.iou_ratio, rsp_data.overlap_area,
                           rsp_data.union_area);
            end else begin
               want = due_results.pop_front();
               if (want.iou_ratio !== rsp_data.iou_ratio
                   || want.overlap_area !== rsp_data.overlap_area
                   || want.union_area !== rsp_data.union_area) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("box_iou mismatch: ratio exp %0d got %0d",
                              want.iou_ratio, rsp_data.iou_ratio);
                     $display("   overlap exp %0d got %0d",
                              want.overlap_area, rsp_data.overlap_area);
                     $display("   union exp %0d got %0d",
                              want.union_area, rsp_data.union_area);
                  end
               end
            end
         end
         if (start && !busy)
            due_results.push_back(iou_of(req_data));
         pending_count = due_results.size();
      end
   end

endmodule

[test/tb_box_iou.sv]
// ----------------------------------------------------------------------------
// tb_box_iou
// Drives box pairs into box_iou: a directed set covering field extremes,
// disjoint, touching, contained, identical and zero-area boxes, then random
// pairs, most of them overlapping. Start idles at random except for one long
// stretch. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_box_iou;

   localparam int RATIO_FRAC_BITS = 16;
   localparam int LATENCY         = RATIO_FRAC_BITS + 3;
   localparam int RANDOM_PAIRS    = 950;
   localparam int CYCLE_LIMIT     = 200000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   biou_pkg::req_type req_data = '0;
   logic              rsp_strobe;
   biou_pkg::rsp_type rsp_data;
   int                mismatch_count;
   int                pending_count;
   bit                idle_on = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   box_iou #(.RATIO_FRAC_BITS(RATIO_FRAC_BITS)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   box_iou_checker #(.RATIO_FRAC_BITS(RATIO_FRAC_BITS)) u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .mismatch_count(mismatch_count), .pending_count(pending_count)
   );

   // enter at a falling edge, return at the falling edge after the transfer
   task automatic transfer(biou_pkg::req_type pair);
      if (idle_on) begin
         while ($urandom_range(99) < 28) begin
            start = 1'b0;
            @(negedge clock);
         end
      end
      start    = 1'b1;
      req_data = pair;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_pair(biou_pkg::coord_type cx1, biou_pkg::coord_type cy1,
                            biou_pkg::coord_type w1, biou_pkg::coord_type h1,
                            biou_pkg::coord_type cx2, biou_pkg::coord_type cy2,
                            biou_pkg::coord_type w2, biou_pkg::coord_type h2);
      transfer(biou_pkg::req_type'{cx1, cy1, w1, h1, cx2, cy2, w2, h2});
   endtask

   function automatic biou_pkg::coord_type rand_coord();
      return biou_pkg::coord_type'($urandom_range(0, 65535) >> $urandom_range(0, 12));
   endfunction

   function automatic biou_pkg::coord_type jitter(biou_pkg::coord_type c,
                                                  biou_pkg::coord_type reach);
      return c + biou_pkg::coord_type'($urandom_range(0, reach)) - (reach >> 1);
   endfunction

   function automatic biou_pkg::req_type random_pair();
      biou_pkg::req_type p;
      int                kind;
      kind = $urandom_range(0, 99);
      p.first_center_x = biou_pkg::coord_type'($urandom_range(0, 65535));
      p.first_center_y = biou_pkg::coord_type'($urandom_range(0, 65535));
      p.first_width    = rand_coord();
      p.first_height   = rand_coord();
      if (kind < 30) begin
         p.second_center_x = biou_pkg::coord_type'($urandom_range(0, 65535));
         p.second_center_y = biou_pkg::coord_type'($urandom_range(0, 65535));
         p.second_width    = biou_pkg::coord_type'($urandom_range(0, 65535));
         p.second_height   = biou_pkg::coord_type'($urandom_range(0, 65535));
         p.first_width     = biou_pkg::coord_type'($urandom_range(0, 65535));
         p.first_height    = biou_pkg::coord_type'($urandom_range(0, 65535));
      end else if (kind < 85) begin
         p.second_center_x = jitter(p.first_center_x, p.first_width);
         p.second_center_y = jitter(p.first_center_y, p.first_height);
         p.second_width    = rand_coord();
         p.second_height   = rand_coord();
      end else begin
         p.second_center_x = jitter(p.first_center_x,
                                    biou_pkg::coord_type'($urandom_range(0, 3)));
         p.second_center_y = jitter(p.first_center_y,
                                    biou_pkg::coord_type'($urandom_range(0, 3)));
         p.second_width    = jitter(p.first_width,
                                    biou_pkg::coord_type'($urandom_range(0, 3)));
         p.second_height   = jitter(p.first_height,
                                    biou_pkg::coord_type'($urandom_range(0, 3)));
      end
      return p;
   endfunction

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("box_iou test failed");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_pair(0, 0, 0, 0, 0, 0, 0, 0);
      send_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_pair(100, 100, 40, 30, 100, 100, 40, 30);
      send_pair(100, 100, 20, 20, 200, 100, 20, 20);
      send_pair(100, 100, 20, 20, 100, 200, 20, 20);
      send_pair(100, 100, 20, 20, 120, 100, 20, 20);
      send_pair(100, 100, 20, 20, 100, 120, 20, 20);
      send_pair(500, 500, 200, 200, 500, 500, 50, 50);
      send_pair(100, 100, 60, 40, 130, 110, 60, 40);
      send_pair(100, 100, 0, 50, 100, 100, 0, 50);
      send_pair(100, 100, 0, 50, 100, 100, 40, 40);
      send_pair(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1);
      send_pair(0, 0, 16'hFFFF, 16'hFFFF, 0, 0, 16'hFFFF, 1);
      send_pair(0, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_pair(1000, 1000, 16, 16, 1015, 1000, 16, 16);
      send_pair(0, 16'hFFFF, 16'hFFFF, 0, 16'hFFFF, 0, 0, 16'hFFFF);
      send_pair(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
      send_pair(5, 5, 100, 100, 10, 10, 100, 100);
      send_pair(16'h8000, 16'h8000, 16'h7FFF, 16'h8000,
                16'h8001, 16'h7FFF, 16'h8000, 16'h7FFF);

      for (int i = 0; i < RANDOM_PAIRS; i++) begin
         idle_on = !(i >= 300 && i < 500);
         transfer(random_pair());
      end
      start = 1'b0;

      wait (pending_count == 0);
      repeat (LATENCY + 6) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("box_iou test passed");
      else
         $display("box_iou test failed");
      $finish;
   end

endmodule
